>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define PEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define PEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pegen_pkg.sv
// ----------------------------------------------------------------------------
// pegen_pkg
// Types and constants shared by the pointer event generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pegen_pkg;

  // Field widths
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W     = 17;
  localparam int ABS_W     = 16;
  localparam int WHEEL_W   = 8;
  localparam int BTN_W     = 3;
  localparam int MOD_W     = 8;
  localparam int KIND_W    = 2;
  localparam int EVB_W     = 2;
  localparam int NUM_EV    = 5;

  // Cursor storage must hold the default screen centre at any coordinate width
  localparam int CUR_MIN_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEF_WIDTH  = 13'd1024;
  localparam logic [CFG_W-1:0] DEF_HEIGHT = 13'd768;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_DOWN  = 2'd0;
  localparam logic [KIND_W-1:0] EV_UP    = 2'd1;
  localparam logic [KIND_W-1:0] EV_MOVE  = 2'd2;
  localparam logic [KIND_W-1:0] EV_WHEEL = 2'd3;

  // Event button codes
  localparam logic [EVB_W-1:0] BTN_NONE   = 2'd0;
  localparam logic [EVB_W-1:0] BTN_LEFT   = 2'd1;
  localparam logic [EVB_W-1:0] BTN_RIGHT  = 2'd2;
  localparam logic [EVB_W-1:0] BTN_MIDDLE = 2'd3;

  // Bit positions in the pending event mask, in emission order
  localparam int PEND_LEFT   = 0;
  localparam int PEND_RIGHT  = 1;
  localparam int PEND_MIDDLE = 2;
  localparam int PEND_MOVE   = 3;
  localparam int PEND_WHEEL  = 4;

  // One mouse packet
  typedef struct packed {
    logic                      rel;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [WHEEL_W-1:0] wheel;
    logic [BTN_W-1:0]          buttons;
    logic [MOD_W-1:0]          mods;
  } pkt_t;

  // Events still owed for one packet
  typedef struct packed {
    logic [NUM_EV-1:0]         pending;
    logic [BTN_W-1:0]          buttons;
    logic [MOD_W-1:0]          mods;
    logic signed [WHEEL_W-1:0] wheel;
  } rec_t;

endpackage

`default_nettype wire

>>> rtl/pointer_event_generator.sv
// Path: a request goes through the input, scaling and record registers to the output register.
// Throughput: one event per cycle while out_stall is low; a request holds the event sequencer
//   until it has sent its last event (1 to 5 events); a request with no events never enters it.
// The sequencer limits the rate: a new request enters tracking only when the previous one
//   has handed out its last event. Reset (synchronous, active low) empties the pipeline,
//   sets the screen to 1024x768, the cursor to 512,384 and the button state to none held.
`default_nettype none

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// pointer_event_generator
// Turns mouse requests into button, move and wheel events with cursor tracking.
// ----------------------------------------------------------------------------
module pointer_event_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pegen_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pegen_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_is_relative_move,
  input  logic signed [pegen_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [pegen_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [pegen_pkg::WHEEL_W-1:0] in_wheel,
  input  logic [pegen_pkg::BTN_W-1:0]          in_button_mask,
  input  logic [pegen_pkg::MOD_W-1:0]          in_modifier_keys,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pegen_pkg::KIND_W-1:0]         out_event_kind,
  output logic [COORD_BITS-1:0]                out_cursor_x,
  output logic [COORD_BITS-1:0]                out_cursor_y,
  output logic [pegen_pkg::BTN_W-1:0]          out_held_buttons,
  output logic [pegen_pkg::EVB_W-1:0]          out_event_button,
  output logic [pegen_pkg::MOD_W-1:0]          out_event_modifiers,
  output logic signed [pegen_pkg::WHEEL_W-1:0] out_wheel_delta,
  output logic                                 out_last_event
);
  import pegen_pkg::*;

  pkt_t                          in_pkt;
  pkt_t                          s2_pkt;
  logic                          s2_valid;
  logic                          s2_take;
  logic [ABS_W+COORD_BITS:0]     prod_x, prod_y;
  logic [COORD_BITS:0]           eff_w, eff_h;
  logic                          rec_load;
  logic                          rec_free;
  rec_t                          rec;
  logic [COORD_BITS-1:0]         cur_x, cur_y;

  // Gather the request fields
  always_comb begin
    in_pkt.rel     = in_is_relative_move;
    in_pkt.pos_x   = in_pos_x;
    in_pkt.pos_y   = in_pos_y;
    in_pkt.wheel   = in_wheel;
    in_pkt.buttons = in_button_mask;
    in_pkt.mods    = in_modifier_keys;
  end

  pegen_scale #(.COORD_BITS(COORD_BITS)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pkt   (in_pkt),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .s2_take  (s2_take),
    .s2_valid (s2_valid),
    .s2_pkt   (s2_pkt),
    .prod_x   (prod_x),
    .prod_y   (prod_y)
  );

  pegen_track #(.COORD_BITS(COORD_BITS)) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s2_valid  (s2_valid),
    .s2_pkt    (s2_pkt),
    .prod_x    (prod_x),
    .prod_y    (prod_y),
    .rec_free  (rec_free),
    .s2_take   (s2_take),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .rec_load  (rec_load),
    .rec       (rec),
    .cur_x     (cur_x),
    .cur_y     (cur_y)
  );

  pegen_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_load            (rec_load),
    .rec_in              (rec),
    .cur_x               (cur_x),
    .cur_y               (cur_y),
    .rec_free            (rec_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_cursor_x        (out_cursor_x),
    .out_cursor_y        (out_cursor_y),
    .out_held_buttons    (out_held_buttons),
    .out_event_button    (out_event_button),
    .out_event_modifiers (out_event_modifiers),
    .out_wheel_delta     (out_wheel_delta),
    .out_last_event      (out_last_event)
  );

  // Wheel amount only travels in wheel events
  `PEG_ASSERT_NOW(a_wheel_only_in_wheel_ev, out_valid && out_event_kind != EV_WHEEL, out_wheel_delta == '0, "wheel delta outside a wheel event")
  // Wheel event always closes its request
  `PEG_ASSERT_NOW(a_wheel_ev_is_last, out_valid && out_event_kind == EV_WHEEL, out_last_event, "wheel event not marked last")
  // Button events name a button
  `PEG_ASSERT_NOW(a_button_ev_has_button, out_valid && (out_event_kind == EV_DOWN || out_event_kind == EV_UP), out_event_button != BTN_NONE, "button event without a button")
  // Events of one request leave back to back
  `PEG_ASSERT_NEXT(a_events_back_to_back, out_valid && !out_stall && !out_last_event, out_valid, "gap inside a request's events")

endmodule

`default_nettype wire

>>> rtl/pegen_scale.sv
// ----------------------------------------------------------------------------
// pegen_scale
// Input register and absolute-coordinate scaling stage (coord * screen size).
// ----------------------------------------------------------------------------
`default_nettype none

module pegen_scale #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pegen_pkg::pkt_t                       in_pkt,
  input  logic [COORD_BITS:0]                   eff_w,
  input  logic [COORD_BITS:0]                   eff_h,
  input  logic                                  s2_take,
  output logic                                  s2_valid,
  output pegen_pkg::pkt_t                       s2_pkt,
  output logic [pegen_pkg::ABS_W+COORD_BITS:0]  prod_x,
  output logic [pegen_pkg::ABS_W+COORD_BITS:0]  prod_y
);
  import pegen_pkg::*;

  localparam int PROD_W = ABS_W + COORD_BITS + 1;

  logic              s1_valid_r, s1_valid_nxt;
  pkt_t              s1_pkt_r;
  logic              s2_valid_r, s2_valid_nxt;
  pkt_t              s2_pkt_r;
  logic [PROD_W-1:0] prod_x_r, prod_x_nxt;
  logic [PROD_W-1:0] prod_y_r, prod_y_nxt;
  logic              s2_free;
  logic              s1_move;
  logic              in_acc;
  logic [ABS_W-1:0]  ax;
  logic [ABS_W-1:0]  ay;

  // Stage flow control
  assign s2_free  = !s2_valid_r || s2_take;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;

  // Negative absolute coordinates map to zero
  assign ax = s1_pkt_r.pos_x[POS_W-1] ? '0 : s1_pkt_r.pos_x[ABS_W-1:0];
  assign ay = s1_pkt_r.pos_y[POS_W-1] ? '0 : s1_pkt_r.pos_y[ABS_W-1:0];

  // Scale by the screen size
  assign prod_x_nxt = s1_move ? PROD_W'(ax) * PROD_W'(eff_w) : prod_x_r;
  assign prod_y_nxt = s1_move ? PROD_W'(ay) * PROD_W'(eff_h) : prod_y_r;

  // Advance valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_move) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_take) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pkt_r <= in_pkt;
    end
    if (s1_move) begin
      s2_pkt_r <= s1_pkt_r;
    end
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
  end

  assign s2_valid = s2_valid_r;
  assign s2_pkt   = s2_pkt_r;
  assign prod_x   = prod_x_r;
  assign prod_y   = prod_y_r;

endmodule

`default_nettype wire

>>> rtl/pegen_track.sv
// ----------------------------------------------------------------------------
// pegen_track
// Screen size registers, cursor and button state, clamping and event mask.
// ----------------------------------------------------------------------------
`default_nettype none

module pegen_track #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pegen_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pegen_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  s2_valid,
  input  pegen_pkg::pkt_t                       s2_pkt,
  input  logic [pegen_pkg::ABS_W+COORD_BITS:0]  prod_x,
  input  logic [pegen_pkg::ABS_W+COORD_BITS:0]  prod_y,
  input  logic                                  rec_free,
  output logic                                  s2_take,
  output logic [COORD_BITS:0]                   eff_w,
  output logic [COORD_BITS:0]                   eff_h,
  output logic                                  rec_load,
  output pegen_pkg::rec_t                       rec,
  output logic [COORD_BITS-1:0]                 cur_x,
  output logic [COORD_BITS-1:0]                 cur_y
);
  import pegen_pkg::*;

  localparam int CUR_W  = (COORD_BITS > CUR_MIN_W) ? COORD_BITS : CUR_MIN_W;
  localparam int XW     = CUR_W + 1;
  localparam int SUM_W  = ((CUR_W + 1 > POS_W) ? CUR_W + 1 : POS_W) + 1;
  localparam int PROD_W = ABS_W + COORD_BITS + 1;
  localparam int Q_W    = COORD_BITS + 2;
  localparam int CMP_W  = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;

  // Effective size: zero reads as one, anything above 2^COORD_BITS saturates
  function automatic logic [COORD_BITS:0] eff_size(input logic [CFG_W-1:0] r);
    logic [CMP_W-1:0] r_ext;
    logic [CMP_W-1:0] lim;
    r_ext = CMP_W'(r);
    lim   = CMP_W'(1) << COORD_BITS;
    if (r_ext == '0) return (COORD_BITS+1)'(1);
    else if (r_ext > lim) return lim[COORD_BITS:0];
    else return r_ext[COORD_BITS:0];
  endfunction

  // Clamp a signed cursor sum to 0..mx
  function automatic logic [CUR_W-1:0] rel_clamp(input logic signed [SUM_W-1:0] s,
                                                  input logic [COORD_BITS:0] mx);
    logic signed [SUM_W-1:0] mx_s;
    mx_s = SUM_W'(mx);
    if (s < 0) return '0;
    else if (s > mx_s) return CUR_W'(mx);
    else return CUR_W'(s);
  endfunction

  // Divide the scaled coordinate by 0xffff, then clamp to mx
  function automatic logic [CUR_W-1:0] abs_clamp(input logic [PROD_W-1:0] p,
                                                  input logic [COORD_BITS:0] mx);
    logic [PROD_W:0] acc;
    logic [Q_W-1:0]  q;
    acc = (PROD_W+1)'(p) + (PROD_W+1)'(p >> ABS_W) + (PROD_W+1)'(1);
    q   = acc[PROD_W:ABS_W];
    if (q > Q_W'(mx)) return CUR_W'(mx);
    else return CUR_W'(q);
  endfunction

  // Pull a stored cursor down to mx
  function automatic logic [CUR_W-1:0] hi_clamp(input logic [CUR_W-1:0] c,
                                                 input logic [COORD_BITS:0] mx);
    if (XW'(c) > XW'(mx)) return CUR_W'(mx);
    else return c;
  endfunction

  logic [CFG_W-1:0]        width_r, width_nxt;
  logic [CFG_W-1:0]        height_r, height_nxt;
  logic [CUR_W-1:0]        cur_x_r, cur_x_nxt;
  logic [CUR_W-1:0]        cur_y_r, cur_y_nxt;
  logic [BTN_W-1:0]        prev_btn_r, prev_btn_nxt;
  logic [COORD_BITS:0]     max_x, max_y;
  logic [CFG_W-1:0]        cfg_w, cfg_h;
  logic [COORD_BITS:0]     cfg_max_x, cfg_max_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [CUR_W-1:0]        new_x, new_y;
  logic                    moved;
  logic [BTN_W-1:0]        changed;

  // Current limits
  assign eff_w = eff_size(width_r);
  assign eff_h = eff_size(height_r);
  assign max_x = eff_w - (COORD_BITS+1)'(1);
  assign max_y = eff_h - (COORD_BITS+1)'(1);

  // New cursor position for the packet in stage 2
  assign sum_x = SUM_W'($signed({1'b0, cur_x_r})) + SUM_W'(s2_pkt.pos_x);
  assign sum_y = SUM_W'($signed({1'b0, cur_y_r})) + SUM_W'(s2_pkt.pos_y);
  assign new_x = s2_pkt.rel ? rel_clamp(sum_x, max_x) : abs_clamp(prod_x, max_x);
  assign new_y = s2_pkt.rel ? rel_clamp(sum_y, max_y) : abs_clamp(prod_y, max_y);
  assign moved = (new_x != cur_x_r) || (new_y != cur_y_r);
  assign changed = prev_btn_r ^ s2_pkt.buttons;

  // Hand the packet on once the emitter has room
  assign s2_take = s2_valid && rec_free;

  always_comb begin
    rec.pending              = '0;
    rec.pending[PEND_LEFT]   = changed[0];
    rec.pending[PEND_RIGHT]  = changed[1];
    rec.pending[PEND_MIDDLE] = changed[2];
    rec.pending[PEND_MOVE]   = moved;
    rec.pending[PEND_WHEEL]  = (s2_pkt.wheel != '0);
    rec.buttons              = s2_pkt.buttons;
    rec.mods                 = s2_pkt.mods;
    rec.wheel                = s2_pkt.wheel;
  end

  // Drop packets that cause no event
  assign rec_load = s2_take && (rec.pending != '0);

  // Size after a register write, and the cursor limits it gives
  assign cfg_w     = (cfg_index == REG_SCREEN_WIDTH)  ? cfg_data : width_r;
  assign cfg_h     = (cfg_index == REG_SCREEN_HEIGHT) ? cfg_data : height_r;
  assign cfg_max_x = eff_size(cfg_w) - (COORD_BITS+1)'(1);
  assign cfg_max_y = eff_size(cfg_h) - (COORD_BITS+1)'(1);

  // Update state on a packet; otherwise store a size write and clamp the cursor to it
  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    prev_btn_nxt = prev_btn_r;
    if (s2_take) begin
      cur_x_nxt    = new_x;
      cur_y_nxt    = new_y;
      prev_btn_nxt = s2_pkt.buttons;
    end else if (cfg_we) begin
      width_nxt  = cfg_w;
      height_nxt = cfg_h;
      cur_x_nxt  = hi_clamp(cur_x_r, cfg_max_x);
      cur_y_nxt  = hi_clamp(cur_y_r, cfg_max_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DEF_WIDTH;
      height_r   <= DEF_HEIGHT;
      cur_x_r    <= CUR_W'(DEF_WIDTH / 2);
      cur_y_r    <= CUR_W'(DEF_HEIGHT / 2);
      prev_btn_r <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      prev_btn_r <= prev_btn_nxt;
    end
  end

  assign cur_x = cur_x_r[COORD_BITS-1:0];
  assign cur_y = cur_y_r[COORD_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/pegen_emit.sv
// ----------------------------------------------------------------------------
// pegen_emit
// Event sequencer: sends the pending events of one packet, one per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pegen_emit #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rec_load,
  input  pegen_pkg::rec_t                      rec_in,
  input  logic [COORD_BITS-1:0]                cur_x,
  input  logic [COORD_BITS-1:0]                cur_y,
  output logic                                 rec_free,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pegen_pkg::KIND_W-1:0]         out_event_kind,
  output logic [COORD_BITS-1:0]                out_cursor_x,
  output logic [COORD_BITS-1:0]                out_cursor_y,
  output logic [pegen_pkg::BTN_W-1:0]          out_held_buttons,
  output logic [pegen_pkg::EVB_W-1:0]          out_event_button,
  output logic [pegen_pkg::MOD_W-1:0]          out_event_modifiers,
  output logic signed [pegen_pkg::WHEEL_W-1:0] out_wheel_delta,
  output logic                                 out_last_event
);
  import pegen_pkg::*;

  logic [NUM_EV-1:0]         pend_r, pend_nxt;
  rec_t                      rec_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]         kind_r;
  logic [COORD_BITS-1:0]     cx_r, cy_r;
  logic [BTN_W-1:0]          held_r;
  logic [EVB_W-1:0]          btn_r;
  logic [MOD_W-1:0]          mods_r;
  logic signed [WHEEL_W-1:0] wheel_r;
  logic                      last_r;
  logic                      out_free;
  logic                      emit;
  logic [NUM_EV-1:0]         low_bit;
  logic [NUM_EV-1:0]         rest;
  logic                      is_last;
  logic [KIND_W-1:0]         kind_sel;
  logic [EVB_W-1:0]          btn_sel;
  logic signed [WHEEL_W-1:0] wheel_sel;

  // Pick the lowest pending event
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (pend_r != '0) && out_free;
  assign low_bit  = pend_r & (~pend_r + NUM_EV'(1));
  assign rest     = pend_r & ~low_bit;
  assign is_last  = (rest == '0);
  assign rec_free = (pend_r == '0) || (emit && is_last);

  always_comb begin
    kind_sel  = EV_MOVE;
    btn_sel   = BTN_NONE;
    wheel_sel = '0;
    priority if (pend_r[PEND_LEFT]) begin
      kind_sel = rec_r.buttons[0] ? EV_DOWN : EV_UP;
      btn_sel  = BTN_LEFT;
    end else if (pend_r[PEND_RIGHT]) begin
      kind_sel = rec_r.buttons[1] ? EV_DOWN : EV_UP;
      btn_sel  = BTN_RIGHT;
    end else if (pend_r[PEND_MIDDLE]) begin
      kind_sel = rec_r.buttons[2] ? EV_DOWN : EV_UP;
      btn_sel  = BTN_MIDDLE;
    end else if (pend_r[PEND_WHEEL] && !pend_r[PEND_MOVE]) begin
      kind_sel  = EV_WHEEL;
      wheel_sel = rec_r.wheel;
    end else begin
      kind_sel = EV_MOVE;
    end
  end

  // Load a new packet or drop the event just sent
  always_comb begin
    pend_nxt = pend_r;
    if (rec_load) begin
      pend_nxt = rec_in.pending;
    end else if (emit) begin
      pend_nxt = rest;
    end
  end

  // Output register holds a taken event until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec_in;
    end
    if (emit) begin
      kind_r  <= kind_sel;
      cx_r    <= cur_x;
      cy_r    <= cur_y;
      held_r  <= rec_r.buttons;
      btn_r   <= btn_sel;
      mods_r  <= rec_r.mods;
      wheel_r <= wheel_sel;
      last_r  <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = kind_r;
  assign out_cursor_x        = cx_r;
  assign out_cursor_y        = cy_r;
  assign out_held_buttons    = held_r;
  assign out_event_button    = btn_r;
  assign out_event_modifiers = mods_r;
  assign out_wheel_delta     = wheel_r;
  assign out_last_event      = last_r;

endmodule

`default_nettype wire
